[src/qppn_pkg.sv]
// qppn_pkg: shared constants and types for the quadratic patch perturbed normal block
// used by qppn_short, qppn_norm and quadratic_patch_perturbed_normal
package qppn_pkg;

	typedef logic signed [31:0] q30_t;

	localparam int SLOT_BITS = 21;
	localparam int THR_BITS = 16;
	localparam logic [THR_BITS-1:0] THR_RESET = 16'd1;
	localparam q30_t ONE_Q30 = 32'sh4000_0000;

	// latency of the vector normalizer and of the short-vector check, in enabled cycles
	localparam int NORM_LAT = 71;
	localparam int SHORT_LAT = 3;

endpackage

[src/qppn_short.sv]
// qppn_short: pipelined test whether a 3-vector is shorter than the threshold
// magnitudes are shifted right by SH first; depends on qppn_pkg
module qppn_short import qppn_pkg::*; #(
	parameter int W = 45,
	parameter int SH = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0][W-1:0]     vec,
	input  logic [THR_BITS-1:0]   thr,
	output logic                  short_s3
);

	localparam int MW = W - SH;

	logic [2:0][MW-1:0] m_s1;
	logic [2:0]         lt_s2;
	logic [2:0][31:0]   sq_s2;
	logic [31:0]        thr2_s2;
	logic [W-1:0]       mag [3];
	logic [33:0]        sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
		end
		sum = 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]  <= mag[i][W-1:SH];
				lt_s2[i] <= m_s1[i] < MW'(thr);
				sq_s2[i] <= 32'(m_s1[i][15:0]) * 32'(m_s1[i][15:0]);
			end
			thr2_s2  <= 32'(thr) * 32'(thr);
			short_s3 <= (&lt_s2) && (sum < 34'(thr2_s2));
		end
	end

endmodule

[src/qppn_norm.sv]
// qppn_norm: pipelined unit-vector normalizer producing signed Q1.30 components
// scale to [2^29, 2^30), digit-by-digit square root, restoring division; uses qppn_pkg
module qppn_norm import qppn_pkg::*; #(
	parameter int W = 45
) (
	input  logic              clk,
	input  logic              en,
	input  logic [2:0][W-1:0] vec,
	output logic [2:0][31:0]  unit_q
);

	localparam int PW  = $clog2(W);
	localparam int XW  = (W > 30) ? W : 30;
	localparam int SQW = 64;
	localparam int DW  = 61;
	localparam int QW  = 31;

	logic [2:0][W-1:0]  mag_s1, mag_s2, mag_s3;
	logic [2:0]         neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [W-1:0]       mx, mx_s2;
	logic [PW-1:0]      pos, pos_s3;
	logic               zero_s3, zero_s4, zero_s5;
	logic [2:0][29:0]   msh, msh_s4, msh_s5;
	logic [2:0][59:0]   sq_s5;
	logic [XW-1:0]      ext [3];

	// root stages, index 0 holds the sum of squares
	logic [SQW-1:0]     rx_s   [0:32];
	logic [SQW-1:0]     rr_s   [0:32];
	logic [2:0][29:0]   rm_s   [0:32];
	logic [2:0]         rneg_s [0:32];
	logic               rzero_s[0:32];

	// division stages
	logic [2:0][DW-1:0] dr_s    [0:31];
	logic [2:0][QW-1:0] dq_s    [0:31];
	logic [QW-1:0]      dlen_s  [0:31];
	logic [2:0]         dneg_s  [0:31];
	logic               dzero_s [0:31];

	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) mx = mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
		pos = '0;
		for (int b = 0; b < W; b++) begin
			if (mx_s2[b]) pos = PW'(b);
		end
		for (int i = 0; i < 3; i++) begin
			ext[i] = XW'(mag_s3[i]);
			if (int'(pos_s3) >= 29) ext[i] = ext[i] >> (int'(pos_s3) - 29);
			else ext[i] = ext[i] << (29 - int'(pos_s3));
			msh[i] = ext[i][29:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][W-1];
				mag_s1[i] <= vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
				sq_s5[i]  <= 60'(msh_s4[i]) * 60'(msh_s4[i]);
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			mx_s2   <= mx;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			pos_s3  <= pos;
			zero_s3 <= (mx_s2 == '0);
			msh_s4  <= msh;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			msh_s5  <= msh_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			rx_s[0]    <= SQW'(sq_s5[0]) + SQW'(sq_s5[1]) + SQW'(sq_s5[2]);
			rr_s[0]    <= '0;
			rm_s[0]    <= msh_s5;
			rneg_s[0]  <= neg_s5;
			rzero_s[0] <= zero_s5;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_root
		localparam logic [SQW-1:0] BIT = SQW'(1) << (62 - 2 * k);
		logic [SQW-1:0] trial;
		assign trial = rr_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rx_s[k] >= trial) begin
					rx_s[k+1] <= rx_s[k] - trial;
					rr_s[k+1] <= (rr_s[k] >> 1) + BIT;
				end else begin
					rx_s[k+1] <= rx_s[k];
					rr_s[k+1] <= rr_s[k] >> 1;
				end
				rm_s[k+1]    <= rm_s[k];
				rneg_s[k+1]  <= rneg_s[k];
				rzero_s[k+1] <= rzero_s[k];
			end
		end
	end

	// numerator is m * 2^30 plus half the length, for round half up
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dr_s[0][i] <= DW'({rm_s[32][i], 30'b0}) + DW'(rr_s[32][QW-1:1]);
			end
			dq_s[0]    <= '0;
			dlen_s[0]  <= rr_s[32][QW-1:0];
			dneg_s[0]  <= rneg_s[32];
			dzero_s[0] <= rzero_s[32];
		end
	end

	for (genvar j = 0; j < 31; j++) begin : g_div
		localparam logic [QW-1:0] QBIT = QW'(1) << (30 - j);
		logic [DW-1:0] dvs;
		assign dvs = DW'(dlen_s[j]) << (30 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dr_s[j][i] >= dvs) begin
						dr_s[j+1][i] <= dr_s[j][i] - dvs;
						dq_s[j+1][i] <= dq_s[j][i] | QBIT;
					end else begin
						dr_s[j+1][i] <= dr_s[j][i];
						dq_s[j+1][i] <= dq_s[j][i];
					end
				end
				dlen_s[j+1]  <= dlen_s[j];
				dneg_s[j+1]  <= dneg_s[j];
				dzero_s[j+1] <= dzero_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dzero_s[31]) unit_q[i] <= '0;
				else if (dneg_s[31][i]) unit_q[i] <= ~{1'b0, dq_s[31][i]} + 1'b1;
				else unit_q[i] <= {1'b0, dq_s[31][i]};
			end
		end
	end

endmodule

[src/quadratic_patch_perturbed_normal.sv]
// quadratic_patch_perturbed_normal: unit face normal tilted by a quadratic patch gradient
// one word per cycle sustained while the result side does not stall, from accepted word to result word
// through two 71-stage normalizers (32 root steps, 31 division steps each) in series
// a stall on the result side freezes the whole pipeline; nothing is lost or repeated
// reset clears all valid bits and sets the degenerate threshold thr_q to 1
// depends on qppn_pkg, qppn_short, qppn_norm
module quadratic_patch_perturbed_normal import qppn_pkg::*; #(
	parameter int COORD_BITS = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [THR_BITS-1:0] cfg_data,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic signed [31:0]  coord_u,
	input  logic signed [31:0]  coord_v,
	input  logic signed [31:0]  coef_u,
	input  logic signed [31:0]  coef_v,
	input  logic signed [31:0]  coef_uu,
	input  logic signed [31:0]  coef_uv,
	input  logic signed [31:0]  coef_vv,
	input  logic [62:0]         vertex_base,
	input  logic [62:0]         vertex_second,
	input  logic [62:0]         vertex_third,
	output logic                result_valid,
	input  logic                result_ready,
	output logic signed [31:0]  normal_x,
	output logic signed [31:0]  normal_y,
	output logic signed [31:0]  normal_z,
	output logic                degenerate_face
);

	localparam int EW  = COORD_BITS + 1;
	localparam int RW  = 2 * EW + 1;
	localparam int TOT = 4 + NORM_LAT + 2 + NORM_LAT + 1;
	localparam int DLY = NORM_LAT - SHORT_LAT;

	logic                en;
	logic [TOT-1:0]      valid_s;
	logic [THR_BITS-1:0] thr_q;

	// stage 1: input word
	logic signed [31:0]  u_s1, v_s1, cu_s1, cv_s1, cuu_s1, cuv_s1, cvv_s1;
	logic [62:0]         vb_s1, v2_s1, v3_s1;
	// stage 2: edges and gradient products
	logic [2:0][EW-1:0]  e1_s2, e2_s2;
	logic signed [63:0]  pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [31:0]  cu_s2, cv_s2;
	// stage 3: cross partial products and rounded gradient terms
	logic [2:0][EW-1:0]  e1_s3, e2_s3;
	logic signed [2*EW-1:0] xa_s3 [3];
	logic signed [2*EW-1:0] xb_s3 [3];
	logic signed [49:0]  ta_s3, tb_s3, tc_s3, td_s3;
	logic signed [31:0]  cu_s3, cv_s3;
	// stage 4: face cross product and saturated gradient
	logic [2:0][EW-1:0]  e1_s4, e2_s4;
	logic [2:0][RW-1:0]  raw_s4;
	logic signed [31:0]  gu_s4, gv_s4;

	logic signed [64:0]  ra, rb, rc, rd;
	logic signed [50:0]  gus, gvs;
	logic [2:0][EW-1:0]  e1, e2;

	// alignment around the first normalizers
	logic signed [31:0]  gu_d [NORM_LAT];
	logic signed [31:0]  gv_d [NORM_LAT];
	logic                fs_d [DLY];
	logic                fs_s3;
	logic [2:0][31:0]    n_q, t1_q, t2_q;

	// stages 5 and 6: perturbed vector
	logic signed [63:0]  ga_s5 [3];
	logic signed [63:0]  gb_s5 [3];
	logic [2:0][31:0]    n_s5;
	logic                fs_s5;
	logic [2:0][63:0]    p_s6;
	logic [2:0][31:0]    n_s6;
	logic                fs_s6;

	// alignment around the second normalizer
	logic [2:0][31:0]    nd [NORM_LAT];
	logic                fs2_d [NORM_LAT];
	logic                ps_d [DLY];
	logic                ps_s3;
	logic [2:0][31:0]    r_q;

	// stage 7: result word
	logic signed [31:0]  nx_s7, ny_s7, nz_s7;
	logic                deg_s7;

	function automatic logic signed [EW-1:0] slot(input logic [62:0] w, input int k);
		logic [COORD_BITS-1:0] f;
		f = w[SLOT_BITS*k +: COORD_BITS];
		return EW'($signed(f));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
		if (x > 51'sd2147483647) return 32'sh7fff_ffff;
		if (x < -51'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	assign en           = !result_valid || result_ready;
	assign item_ready   = en;
	assign result_valid = valid_s[TOT-1];
	assign normal_x     = nx_s7;
	assign normal_y     = ny_s7;
	assign normal_z     = nz_s7;
	assign degenerate_face = deg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_write) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[TOT-2:0], item_valid};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = slot(v2_s1, i) - slot(vb_s1, i);
			e2[i] = slot(v3_s1, i) - slot(vb_s1, i);
		end
		// round half up on the Q32.32 products
		ra  = (65'(pa_s2) + 65'sd16384) >>> 15;
		rb  = (65'(pb_s2) + 65'sd32768) >>> 16;
		rc  = (65'(pc_s2) + 65'sd32768) >>> 16;
		rd  = (65'(pd_s2) + 65'sd16384) >>> 15;
		gus = 51'(cu_s3) + 51'(ta_s3) + 51'(tb_s3);
		gvs = 51'(cv_s3) + 51'(tc_s3) + 51'(td_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= coord_u;
			v_s1   <= coord_v;
			cu_s1  <= coef_u;
			cv_s1  <= coef_v;
			cuu_s1 <= coef_uu;
			cuv_s1 <= coef_uv;
			cvv_s1 <= coef_vv;
			vb_s1  <= vertex_base;
			v2_s1  <= vertex_second;
			v3_s1  <= vertex_third;

			e1_s2 <= e1;
			e2_s2 <= e2;
			pa_s2 <= cuu_s1 * u_s1;
			pb_s2 <= cuv_s1 * v_s1;
			pc_s2 <= cuv_s1 * u_s1;
			pd_s2 <= cvv_s1 * v_s1;
			cu_s2 <= cu_s1;
			cv_s2 <= cv_s1;

			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			xa_s3[0] <= $signed(e1_s2[1]) * $signed(e2_s2[2]);
			xb_s3[0] <= $signed(e1_s2[2]) * $signed(e2_s2[1]);
			xa_s3[1] <= $signed(e1_s2[2]) * $signed(e2_s2[0]);
			xb_s3[1] <= $signed(e1_s2[0]) * $signed(e2_s2[2]);
			xa_s3[2] <= $signed(e1_s2[0]) * $signed(e2_s2[1]);
			xb_s3[2] <= $signed(e1_s2[1]) * $signed(e2_s2[0]);
			ta_s3 <= ra[49:0];
			tb_s3 <= rb[49:0];
			tc_s3 <= rc[49:0];
			td_s3 <= rd[49:0];
			cu_s3 <= cu_s2;
			cv_s3 <= cv_s2;

			e1_s4 <= e1_s3;
			e2_s4 <= e2_s3;
			for (int i = 0; i < 3; i++) begin
				raw_s4[i] <= RW'(xa_s3[i]) - RW'(xb_s3[i]);
			end
			gu_s4 <= sat32(gus);
			gv_s4 <= sat32(gvs);
		end
	end

	qppn_short #(.W(RW), .SH(0)) u_face_short (
		.clk      (clk),
		.en       (en),
		.vec      (raw_s4),
		.thr      (thr_q),
		.short_s3 (fs_s3)
	);

	qppn_norm #(.W(RW)) u_norm_face (
		.clk    (clk),
		.en     (en),
		.vec    (raw_s4),
		.unit_q (n_q)
	);

	qppn_norm #(.W(EW)) u_norm_e1 (
		.clk    (clk),
		.en     (en),
		.vec    (e1_s4),
		.unit_q (t1_q)
	);

	qppn_norm #(.W(EW)) u_norm_e2 (
		.clk    (clk),
		.en     (en),
		.vec    (e2_s4),
		.unit_q (t2_q)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			gu_d[0] <= gu_s4;
			gv_d[0] <= gv_s4;
			for (int k = 1; k < NORM_LAT; k++) begin
				gu_d[k] <= gu_d[k-1];
				gv_d[k] <= gv_d[k-1];
			end
			fs_d[0] <= fs_s3;
			for (int k = 1; k < DLY; k++) begin
				fs_d[k] <= fs_d[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				ga_s5[i] <= gu_d[NORM_LAT-1] * $signed(t1_q[i]);
				gb_s5[i] <= gv_d[NORM_LAT-1] * $signed(t2_q[i]);
				p_s6[i]  <= {{16{n_s5[i][31]}}, n_s5[i], 16'b0} - ga_s5[i] - gb_s5[i];
			end
			n_s5  <= n_q;
			fs_s5 <= fs_d[DLY-1];
			n_s6  <= n_s5;
			fs_s6 <= fs_s5;
		end
	end

	qppn_short #(.W(64), .SH(16)) u_pert_short (
		.clk      (clk),
		.en       (en),
		.vec      (p_s6),
		.thr      (thr_q),
		.short_s3 (ps_s3)
	);

	qppn_norm #(.W(64)) u_norm_pert (
		.clk    (clk),
		.en     (en),
		.vec    (p_s6),
		.unit_q (r_q)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			nd[0]    <= n_s6;
			fs2_d[0] <= fs_s6;
			for (int k = 1; k < NORM_LAT; k++) begin
				nd[k]    <= nd[k-1];
				fs2_d[k] <= fs2_d[k-1];
			end
			ps_d[0] <= ps_s3;
			for (int k = 1; k < DLY; k++) begin
				ps_d[k] <= ps_d[k-1];
			end

			if (fs2_d[NORM_LAT-1]) begin
				// flat face: fixed up vector
				nx_s7  <= '0;
				ny_s7  <= ONE_Q30;
				nz_s7  <= '0;
				deg_s7 <= 1'b1;
			end else if (ps_d[DLY-1]) begin
				// perturbed vector vanished: keep the face normal
				nx_s7  <= nd[NORM_LAT-1][0];
				ny_s7  <= nd[NORM_LAT-1][1];
				nz_s7  <= nd[NORM_LAT-1][2];
				deg_s7 <= 1'b0;
			end else begin
				nx_s7  <= r_q[0];
				ny_s7  <= r_q[1];
				nz_s7  <= r_q[2];
				deg_s7 <= 1'b0;
			end
		end
	end

endmodule

[verif/quadratic_patch_perturbed_normal_tb.sv]
// quadratic_patch_perturbed_normal_tb: checks the perturbed-normal block against its own predictor
// directed and random patch queries, random stalls on both sides, threshold changes between phases
// depends on qppn_pkg and quadratic_patch_perturbed_normal
module quadratic_patch_perturbed_normal_tb import qppn_pkg::*; ();

	localparam int COORD_BITS = 21;

	typedef struct {
		logic signed [31:0] u, v, cu, cv, cuu, cuv, cvv;
		logic [62:0] vb, vs, vt;
	} patch_t;

	typedef struct {
		logic signed [31:0] nx, ny, nz;
		logic degen;
	} normal_t;

	class normal_scoreboard;
		normal_t expected_normals[$];
		logic [THR_BITS-1:0] thr = THR_RESET;
		int errors = 0;

		function automatic longint unsigned root_floor(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function automatic longint unsigned abs64(longint x);
			return x < 0 ? longint'(0) - x : x;
		endfunction

		function automatic bit below_thr(longint unsigned m[3]);
			longint unsigned t;
			t = thr;
			for (int i = 0; i < 3; i++)
				if (m[i] >= t) return 0;
			return m[0] * m[0] + m[1] * m[1] + m[2] * m[2] < t * t;
		endfunction

		// scale to [2^29, 2^30), then divide by the integer length
		function automatic void normalize(input longint c[3], output longint q[3]);
			longint unsigned m[3], mx, sum, len, r;
			int rs, ls;
			mx = 0;
			rs = 0;
			ls = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = abs64(c[i]);
				if (m[i] > mx) mx = m[i];
			end
			if (mx == 0) begin
				q = '{0, 0, 0};
				return;
			end
			while ((mx >> rs) >= (64'd1 << 30)) rs++;
			while ((mx << ls) < (64'd1 << 29)) ls++;
			for (int i = 0; i < 3; i++) m[i] = (m[i] >> rs) << ls;
			sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			len = root_floor(sum);
			for (int i = 0; i < 3; i++) begin
				r = ((m[i] << 30) + (len >> 1)) / len;
				q[i] = c[i] < 0 ? -longint'(r) : longint'(r);
			end
		endfunction

		function automatic longint slot(logic [62:0] w, int k);
			logic signed [COORD_BITS-1:0] f;
			f = w[SLOT_BITS*k +: COORD_BITS];
			return longint'(f);
		endfunction

		function automatic longint clip32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function automatic normal_t tilt_normal(patch_t p);
			longint e1[3], e2[3], face[3], n[3], t1[3], t2[3], pv[3], r[3];
			longint unsigned m[3];
			longint gu, gv, b;
			normal_t res;
			for (int i = 0; i < 3; i++) begin
				b = slot(p.vb, i);
				e1[i] = slot(p.vs, i) - b;
				e2[i] = slot(p.vt, i) - b;
			end
			face[0] = e1[1] * e2[2] - e1[2] * e2[1];
			face[1] = e1[2] * e2[0] - e1[0] * e2[2];
			face[2] = e1[0] * e2[1] - e1[1] * e2[0];
			for (int i = 0; i < 3; i++) m[i] = abs64(face[i]);
			if (below_thr(m)) begin
				res.nx = 0;
				res.ny = ONE_Q30;
				res.nz = 0;
				res.degen = 1;
				return res;
			end
			normalize(face, n);
			normalize(e1, t1);
			normalize(e2, t2);
			// gradient terms rounded half up to Q16.16, sum saturated
			gu = clip32(longint'(p.cu) + ((longint'(p.cuu) * p.u + 16384) >>> 15)
				+ ((longint'(p.cuv) * p.v + 32768) >>> 16));
			gv = clip32(longint'(p.cv) + ((longint'(p.cuv) * p.u + 32768) >>> 16)
				+ ((longint'(p.cvv) * p.v + 16384) >>> 15));
			for (int i = 0; i < 3; i++) begin
				pv[i] = n[i] * 65536 - gu * t1[i] - gv * t2[i];
				m[i] = abs64(pv[i]) >> 16;
			end
			if (below_thr(m))
				r = n;
			else
				normalize(pv, r);
			res.nx = r[0][31:0];
			res.ny = r[1][31:0];
			res.nz = r[2][31:0];
			res.degen = 0;
			return res;
		endfunction

		function void note_input(patch_t p);
			expected_normals = {expected_normals, tilt_normal(p)};
		endfunction

		function void check_result(normal_t got);
			normal_t want;
			if (expected_normals.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h %h %h %b",
					got.nx, got.ny, got.nz, got.degen);
				return;
			end
			want = expected_normals.pop_front();
			if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz
					|| got.degen !== want.degen) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h %h %h %b, got %h %h %h %b",
						want.nx, want.ny, want.nz, want.degen,
						got.nx, got.ny, got.nz, got.degen);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [THR_BITS-1:0] cfg_data = '0;
	logic item_valid = 0;
	logic item_ready;
	logic signed [31:0] coord_u = 0, coord_v = 0, coef_u = 0, coef_v = 0;
	logic signed [31:0] coef_uu = 0, coef_uv = 0, coef_vv = 0;
	logic [62:0] vertex_base = '0, vertex_second = '0, vertex_third = '0;
	logic result_valid;
	logic result_ready = 0;
	logic signed [31:0] normal_x, normal_y, normal_z;
	logic degenerate_face;

	normal_scoreboard sb = new();
	bit calm = 0;
	bit hold_req = 0;

	quadratic_patch_perturbed_normal #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.coord_u(coord_u), .coord_v(coord_v),
		.coef_u(coef_u), .coef_v(coef_v),
		.coef_uu(coef_uu), .coef_uv(coef_uv), .coef_vv(coef_vv),
		.vertex_base(vertex_base), .vertex_second(vertex_second),
		.vertex_third(vertex_third),
		.result_valid(result_valid), .result_ready(result_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate_face(degenerate_face)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("quadratic_patch_perturbed_normal_tb: done, errors");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		int stall_cnt;
		normal_t got;
		stall_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				got.nx = normal_x;
				got.ny = normal_y;
				got.nz = normal_z;
				got.degen = degenerate_face;
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_req = 0;
				stall_cnt = 400;
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				result_ready <= 0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_cnt = $urandom_range(0, 15);
				result_ready <= 0;
			end else
				result_ready <= 1;
		end
	end

	function automatic logic [62:0] pack_vertex(int x, int y, int z);
		return {21'(z), 21'(y), 21'(x)};
	endfunction

	function automatic logic [62:0] rand_vertex(int span);
		if (span == 0) return 63'({$urandom, $urandom});
		return pack_vertex($urandom_range(0, 2 * span) - span,
			$urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
	endfunction

	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom) >>> $urandom_range(8, 31);
			2: return 32'($urandom_range(0, 131072)) - 65536;
			default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		endcase
	endfunction

	task automatic send_patch(patch_t p);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		coord_u <= p.u;
		coord_v <= p.v;
		coef_u <= p.cu;
		coef_v <= p.cv;
		coef_uu <= p.cuu;
		coef_uv <= p.cuv;
		coef_vv <= p.cvv;
		vertex_base <= p.vb;
		vertex_second <= p.vs;
		vertex_third <= p.vt;
		item_valid <= 1;
		do @(posedge clk); while (!item_ready);
		sb.note_input(p);
	endtask

	task automatic drain_and_set(logic [THR_BITS-1:0] thr);
		item_valid <= 0;
		while (sb.expected_normals.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_write <= 1;
		cfg_data <= thr;
		@(posedge clk);
		cfg_write <= 0;
		sb.thr = thr;
	endtask

	function automatic patch_t rand_patch();
		patch_t p;
		int span;
		p.u = rand_q16();
		p.v = rand_q16();
		p.cu = rand_q16();
		p.cv = rand_q16();
		p.cuu = rand_q16();
		p.cuv = rand_q16();
		p.cvv = rand_q16();
		case ($urandom_range(0, 3))
			0: span = 0;
			1: span = 8;
			2: span = 300;
			default: span = 1048575;
		endcase
		p.vb = rand_vertex(span);
		p.vs = rand_vertex(span);
		p.vt = $urandom_range(0, 15) == 0 ? p.vs : rand_vertex(span);
		return p;
	endfunction

	initial begin
		patch_t p;
		logic [THR_BITS-1:0] phase_thr[5];
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset threshold, plain and degenerate faces, field extremes
		p = '{default: '0};
		p.vs = pack_vertex(1024, 0, 0);
		p.vt = pack_vertex(0, 1024, 0);
		send_patch(p);
		p.u = 32'sh7fff_ffff; p.v = 32'sh8000_0000;
		p.cu = 32'sh7fff_ffff; p.cv = 32'sh8000_0000;
		p.cuu = 32'sh7fff_ffff; p.cuv = 32'sh8000_0000; p.cvv = 32'sh7fff_ffff;
		send_patch(p);
		p.u = 32'sh8000_0000; p.v = 32'sh8000_0000;
		p.cuu = 32'sh8000_0000; p.cuv = 32'sh8000_0000; p.cvv = 32'sh8000_0000;
		send_patch(p);
		p.u = 32'sh0001_0000; p.v = 32'sh0000_8000;
		p.cu = 32'sh0000_4000; p.cv = -32'sh0000_4000;
		p.cuu = 0; p.cuv = 32'sh0002_0000; p.cvv = 0;
		p.vb = pack_vertex(-1048576, -1048576, -1048576);
		p.vs = pack_vertex(1048575, -1048576, 1048575);
		p.vt = pack_vertex(-1048576, 1048575, 1048575);
		send_patch(p);
		// collinear vertices
		p.vb = pack_vertex(5, 5, 5);
		p.vs = pack_vertex(10, 10, 10);
		p.vt = pack_vertex(20, 20, 20);
		send_patch(p);
		// all vertices equal
		p.vs = p.vb; p.vt = p.vb;
		send_patch(p);
		p.vb = '1; p.vs = 63'h5555_5555_5555_5555; p.vt = 63'h2aaa_aaaa_aaaa_aaaa;
		send_patch(p);
		p.vb = '0; p.vs = pack_vertex(1, 0, 0); p.vt = pack_vertex(0, 1, 0);
		send_patch(p);

		drain_and_set(16'hffff);
		// small faces below the top threshold, two at or just above it
		p.vb = '0; p.vs = pack_vertex(100, 0, 0); p.vt = pack_vertex(0, 100, 0);
		send_patch(p);
		p.vs = pack_vertex(255, 0, 0); p.vt = pack_vertex(0, 257, 0);
		send_patch(p);
		p.vs = pack_vertex(256, 0, 0); p.vt = pack_vertex(0, 256, 0);
		send_patch(p);
		p.vs = pack_vertex(200, 30, -7); p.vt = pack_vertex(-40, 300, 12);
		send_patch(p);

		drain_and_set(16'h0000);
		p.vs = pack_vertex(0, 0, 0); p.vt = pack_vertex(0, 0, 0);
		send_patch(p);
		p.vs = pack_vertex(1, 0, 0); p.vt = pack_vertex(0, 1, 0);
		send_patch(p);

		// random phases, the last one without idling
		phase_thr = '{16'd1, 16'd0, 16'hffff, 16'($urandom_range(2, 65534)), 16'd1};
		for (int ph = 0; ph < 5; ph++) begin
			drain_and_set(phase_thr[ph]);
			if (ph == 4) calm = 1;
			for (int k = 0; k < 370; k++) begin
				// block fills up while the result side holds off
				if (ph == 1 && k == 20) hold_req = 1;
				send_patch(rand_patch());
			end
		end

		item_valid <= 0;
		while (sb.expected_normals.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("quadratic_patch_perturbed_normal_tb: done, clean");
		else
			$display("quadratic_patch_perturbed_normal_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
src/qppn_pkg.sv
src/qppn_short.sv
src/qppn_norm.sv
src/quadratic_patch_perturbed_normal.sv
verif/quadratic_patch_perturbed_normal_tb.sv
